FILE: src/i2cblm_pkg.sv
package i2cblm_pkg;

	localparam int TICK_W  = 16;
	localparam int PHASE_W = 5;
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 3;

	localparam logic [TICK_W-1:0] PHASE_TICKS_RST = 16'd320;

	localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_START = 3'd1;
	localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ACK   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_NACK  = 3'd6;

	localparam logic LINE_SCL = 1'b0;
	localparam logic LINE_SDA = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] write_byte;
		logic              sda_in;
	} item_t;

	typedef struct packed {
		logic              scl_release;
		logic              sda_release;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_byte;
		logic              rejected;
	} res_t;

	// number of phases in each command
	function automatic logic [PHASE_W-1:0] phase_total(input logic [KIND_W-1:0] cmd);
		logic [PHASE_W-1:0] n;
		case (cmd)
			KIND_START: n = 5'd5;
			KIND_STOP:  n = 5'd4;
			KIND_WRITE: n = 5'd25;
			KIND_READ:  n = 5'd17;
			KIND_ACK:   n = 5'd4;
			KIND_NACK:  n = 5'd2;
			default:    n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

FILE: src/i2c_bit_level_master.sv
// channel  | dir | signals                               | content
// s_axis   | in  | tvalid tready tdata[15:0] tuser[2:0]  | request: tick or command
// m_axis   | out | tvalid tready tdata[15:0]             | line levels and status
// cfg      | in  | valid ready data[15:0]                | phase_ticks
//
// One request per clock sustained while the output is not stalled. A request
// sits in the input register, is evaluated against the phase state and lands in
// the output register when it advances, where the result stays valid until it
// is taken.
// Reset: both lines released, idle, phase_ticks 320, read_byte 0.
// A stalled output holds the input register; s_axis_tready stays high while
// the pending result is taken in the same cycle. cfg is always ready.
module i2c_bit_level_master import i2cblm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // write_byte[7:0], sda_in[8], zero[15:9]
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// scl_release[0], sda_release[1], busy_res[2], done_res[3], read_byte[11:4],
	// rejected[12], zero[15:13]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	item_t             item_s1;
	logic              valid_s2;
	res_t              res_s2;
	res_t              res;
	logic              adv;
	logic [TICK_W-1:0] phase_ticks_q;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_valid) begin
			phase_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind       <= s_axis_tuser;
			item_s1.write_byte <= s_axis_tdata[7:0];
			item_s1.sda_in     <= s_axis_tdata[8];
		end
	end

	i2cblm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (adv),
		.item        (item_s1),
		.phase_ticks (phase_ticks_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.rejected, res_s2.read_byte, res_s2.done_res,
	                        res_s2.busy_res, res_s2.sda_release, res_s2.scl_release};

endmodule

FILE: src/i2cblm_phase.sv
module i2cblm_phase import i2cblm_pkg::*; (
	input  logic [KIND_W-1:0]  cmd,
	input  logic [PHASE_W-1:0] idx,
	input  logic [BYTE_W-1:0]  bits,
	output logic               line,
	output logic               lvl
);

	// write phases: slot within the bit (0 data, 1 SCL high, 2 SCL low) and bit number
	logic [1:0] wr_slot;
	logic [2:0] wr_bit;

	always_comb begin
		wr_slot = 2'd0;
		wr_bit  = 3'd0;
		for (int k = 0; k < 8; k++) begin
			for (int j = 0; j < 3; j++) begin
				if (idx == PHASE_W'(3 * k + j)) begin
					wr_slot = 2'(j);
					wr_bit  = 3'(7 - k);
				end
			end
		end
	end

	always_comb begin
		line = LINE_SCL;
		lvl  = 1'b0;
		case (cmd)
			KIND_START: begin
				case (idx)
					5'd0:    begin line = LINE_SCL; lvl = 1'b0; end
					5'd1:    begin line = LINE_SDA; lvl = 1'b1; end
					5'd2:    begin line = LINE_SCL; lvl = 1'b1; end
					5'd3:    begin line = LINE_SDA; lvl = 1'b0; end
					default: begin line = LINE_SCL; lvl = 1'b0; end
				endcase
			end
			KIND_STOP: begin
				case (idx[1:0])
					2'd0:    begin line = LINE_SCL; lvl = 1'b0; end
					2'd1:    begin line = LINE_SDA; lvl = 1'b0; end
					2'd2:    begin line = LINE_SCL; lvl = 1'b1; end
					default: begin line = LINE_SDA; lvl = 1'b1; end
				endcase
			end
			KIND_WRITE: begin
				if (idx >= 5'd24) begin
					line = LINE_SDA;
					lvl  = 1'b1;
				end else if (wr_slot == 2'd0) begin
					line = LINE_SDA;
					lvl  = bits[wr_bit];
				end else begin
					line = LINE_SCL;
					lvl  = (wr_slot == 2'd1);
				end
			end
			KIND_READ: begin
				if (idx == '0) begin
					line = LINE_SDA;
					lvl  = 1'b1;
				end else begin
					line = LINE_SCL;
					lvl  = idx[0];
				end
			end
			KIND_ACK: begin
				case (idx[1:0])
					2'd0:    begin line = LINE_SDA; lvl = 1'b0; end
					2'd1:    begin line = LINE_SCL; lvl = 1'b1; end
					2'd2:    begin line = LINE_SCL; lvl = 1'b0; end
					default: begin line = LINE_SDA; lvl = 1'b1; end
				endcase
			end
			default: begin
				line = LINE_SCL;
				lvl  = (idx == '0);
			end
		endcase
	end

endmodule

FILE: src/i2cblm_core.sv
module i2cblm_core import i2cblm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  item_t             item,
	input  logic [TICK_W-1:0] phase_ticks,
	output res_t              res
);

	logic               scl_q, sda_q, busy_q;
	logic [KIND_W-1:0]  cmd_q;
	logic [PHASE_W-1:0] idx_q;
	logic [TICK_W-1:0]  tick_q;
	logic [BYTE_W-1:0]  shift_q;
	logic [BYTE_W-1:0]  read_q;

	logic               scl_d, sda_d, busy_d, done_d, rej_d;
	logic [KIND_W-1:0]  cmd_d;
	logic [PHASE_W-1:0] idx_d;
	logic [TICK_W-1:0]  tick_d;
	logic [BYTE_W-1:0]  shift_d;
	logic [BYTE_W-1:0]  read_d;

	logic               is_cmd;
	logic [TICK_W-1:0]  tick_inc, limit;
	logic [PHASE_W-1:0] idx_inc;
	logic [BYTE_W-1:0]  start_shift, shift_adv;
	logic [KIND_W-1:0]  dec_cmd;
	logic [PHASE_W-1:0] dec_idx;
	logic [BYTE_W-1:0]  dec_bits;
	logic               dec_line, dec_lvl;

	assign is_cmd      = item.kind inside {[KIND_START:KIND_NACK]};
	assign tick_inc    = tick_q + 1'b1;
	assign limit       = (phase_ticks == '0) ? TICK_W'(1) : phase_ticks;
	assign idx_inc     = idx_q + 1'b1;
	assign start_shift = (item.kind == KIND_WRITE) ? item.write_byte : '0;
	// read samples SDA at the end of each SCL-high phase (odd phase index)
	assign shift_adv   = (cmd_q == KIND_READ && idx_q[0]) ?
	                     {shift_q[BYTE_W-2:0], item.sda_in} : shift_q;

	// one decoder serves both a new command's first phase and the next phase
	assign dec_cmd  = is_cmd ? item.kind : cmd_q;
	assign dec_idx  = is_cmd ? '0 : idx_inc;
	assign dec_bits = is_cmd ? start_shift : shift_adv;

	i2cblm_phase u_phase (
		.cmd  (dec_cmd),
		.idx  (dec_idx),
		.bits (dec_bits),
		.line (dec_line),
		.lvl  (dec_lvl)
	);

	always_comb begin
		scl_d   = scl_q;
		sda_d   = sda_q;
		busy_d  = busy_q;
		cmd_d   = cmd_q;
		idx_d   = idx_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		read_d  = read_q;
		done_d  = 1'b0;
		rej_d   = 1'b0;
		if (is_cmd) begin
			if (busy_q) begin
				rej_d = 1'b1;
			end else begin
				cmd_d   = item.kind;
				idx_d   = '0;
				shift_d = start_shift;
				busy_d  = 1'b1;
				tick_d  = '0;
				if (dec_line == LINE_SCL) scl_d = dec_lvl;
				else sda_d = dec_lvl;
			end
		end else if (item.kind == KIND_TICK && busy_q) begin
			if (tick_inc >= limit) begin
				shift_d = shift_adv;
				tick_d  = '0;
				if (idx_inc >= phase_total(cmd_q)) begin
					if (cmd_q == KIND_READ) read_d = shift_adv;
					done_d = 1'b1;
					busy_d = 1'b0;
					cmd_d  = KIND_TICK;
					idx_d  = '0;
				end else begin
					idx_d = idx_inc;
					if (dec_line == LINE_SCL) scl_d = dec_lvl;
					else sda_d = dec_lvl;
				end
			end else begin
				tick_d = tick_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			busy_q  <= 1'b0;
			cmd_q   <= KIND_TICK;
			idx_q   <= '0;
			tick_q  <= '0;
			shift_q <= '0;
			read_q  <= '0;
		end else if (step_en) begin
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			busy_q  <= busy_d;
			cmd_q   <= cmd_d;
			idx_q   <= idx_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			read_q  <= read_d;
		end
	end

	assign res = '{
		scl_release: scl_d,
		sda_release: sda_d,
		busy_res:    busy_d,
		done_res:    done_d,
		read_byte:   read_d,
		rejected:    rej_d
	};

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cmd_q == KIND_TICK && idx_q == '0 && tick_q == '0))
		else $error("idle with live command state");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < phase_total(cmd_q)))
		else $error("phase index past end of command");

	a_end_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(step_en && done_d))
		else $error("command ended without done");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && rej_d) |=> busy_q)
		else $error("rejected request while idle");

endmodule

FILE: tb/i2c_bit_level_master_checker.sv
`timescale 1ns / 1ps
module i2c_bit_level_master_checker import i2cblm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // write_byte[7:0], sda_in[8], zero[15:9]
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// scl_release[0], sda_release[1], busy_res[2], done_res[3], read_byte[11:4],
	// rejected[12], zero[15:13]
	input  logic [15:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output int          errors,
	output int          pending
);

	// per-phase line select and level, bit i is phase i
	localparam logic [4:0] START_LINE = 5'b01010;
	localparam logic [4:0] START_LVL  = 5'b00110;
	localparam logic [3:0] STOP_LINE  = 4'b1010;
	localparam logic [3:0] STOP_LVL   = 4'b1100;
	localparam logic [3:0] ACK_LINE   = 4'b1001;
	localparam logic [3:0] ACK_LVL    = 4'b1010;

	logic [TICK_W-1:0]  hold_ticks;
	logic               scl_lvl;
	logic               sda_lvl;
	logic [KIND_W-1:0]  cur_cmd;
	logic [PHASE_W-1:0] phase;
	logic [TICK_W-1:0]  tick_cnt;
	logic [BYTE_W-1:0]  shreg;
	logic               busy;
	logic [BYTE_W-1:0]  last_rd;

	res_t  levels_q[$];
	item_t req;
	res_t  got;
	res_t  want;

	task automatic flag_mismatch(input string what, input logic [15:0] got_v,
			input logic [15:0] want_v);
		$display("%0t ns: %s got %0h want %0h", $time, what, got_v, want_v);
		errors++;
	endtask

	function automatic void drive_phase();
		logic line;
		logic lvl;
		line = LINE_SCL;
		lvl  = 1'b1;
		case (cur_cmd)
			KIND_START: begin
				line = START_LINE[phase];
				lvl  = START_LVL[phase];
			end
			KIND_STOP: begin
				line = STOP_LINE[phase[1:0]];
				lvl  = STOP_LVL[phase[1:0]];
			end
			KIND_WRITE: begin
				if (phase >= 5'd24) begin
					line = LINE_SDA;
					lvl  = 1'b1;
				end else if (phase % 3 == 0) begin
					line = LINE_SDA;
					lvl  = shreg[7 - phase / 3];
				end else begin
					line = LINE_SCL;
					lvl  = (phase % 3 == 1);
				end
			end
			KIND_READ: begin
				if (phase == '0) begin
					line = LINE_SDA;
					lvl  = 1'b1;
				end else begin
					line = LINE_SCL;
					lvl  = phase[0];
				end
			end
			KIND_ACK: begin
				line = ACK_LINE[phase[1:0]];
				lvl  = ACK_LVL[phase[1:0]];
			end
			default: begin
				line = LINE_SCL;
				lvl  = (phase == '0);
			end
		endcase
		if (line == LINE_SCL) begin
			scl_lvl = lvl;
		end else begin
			sda_lvl = lvl;
		end
		tick_cnt = '0;
	endfunction

	function automatic res_t bus_step(input item_t rq);
		res_t               r;
		logic [TICK_W-1:0]  lim;
		logic [PHASE_W-1:0] total;
		r = '0;
		if (rq.kind >= KIND_START && rq.kind <= KIND_NACK) begin
			if (busy) begin
				r.rejected = 1'b1;
			end else begin
				cur_cmd = rq.kind;
				phase   = '0;
				shreg   = (rq.kind == KIND_WRITE) ? rq.write_byte : '0;
				busy    = 1'b1;
				drive_phase();
			end
		end else if (rq.kind == KIND_TICK && busy) begin
			lim = (hold_ticks == '0) ? 16'd1 : hold_ticks;
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= lim) begin
				// sample at the end of each SCL-high phase of a read
				if (cur_cmd == KIND_READ && phase[0]) begin
					shreg = {shreg[6:0], rq.sda_in};
				end
				phase = phase + 1'b1;
				case (cur_cmd)
					KIND_START: total = 5'd5;
					KIND_STOP:  total = 5'd4;
					KIND_WRITE: total = 5'd25;
					KIND_READ:  total = 5'd17;
					KIND_ACK:   total = 5'd4;
					default:    total = 5'd2;
				endcase
				if (phase >= total) begin
					if (cur_cmd == KIND_READ) begin
						last_rd = shreg;
					end
					r.done_res = 1'b1;
					busy     = 1'b0;
					cur_cmd  = KIND_TICK;
					phase    = '0;
					tick_cnt = '0;
				end else begin
					drive_phase();
				end
			end
		end
		r.scl_release = scl_lvl;
		r.sda_release = sda_lvl;
		r.busy_res    = busy;
		r.read_byte   = last_rd;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks = PHASE_TICKS_RST;
			scl_lvl    = 1'b1;
			sda_lvl    = 1'b1;
			cur_cmd    = KIND_TICK;
			phase      = '0;
			tick_cnt   = '0;
			shreg      = '0;
			busy       = 1'b0;
			last_rd    = '0;
			levels_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hold_ticks = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				req.kind       = s_axis_tuser;
				req.write_byte = s_axis_tdata[7:0];
				req.sda_in     = s_axis_tdata[8];
				levels_q.push_back(bus_step(req));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.scl_release = m_axis_tdata[0];
				got.sda_release = m_axis_tdata[1];
				got.busy_res    = m_axis_tdata[2];
				got.done_res    = m_axis_tdata[3];
				got.read_byte   = m_axis_tdata[11:4];
				got.rejected    = m_axis_tdata[12];
				if (levels_q.size() == 0) begin
					flag_mismatch("result with no request", m_axis_tdata, '0);
				end else begin
					want = levels_q.pop_front();
					if (got.scl_release != want.scl_release)
						flag_mismatch("scl_release", 16'(got.scl_release),
							16'(want.scl_release));
					if (got.sda_release != want.sda_release)
						flag_mismatch("sda_release", 16'(got.sda_release),
							16'(want.sda_release));
					if (got.busy_res != want.busy_res)
						flag_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
					if (got.done_res != want.done_res)
						flag_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
					if (got.read_byte != want.read_byte)
						flag_mismatch("read_byte", 16'(got.read_byte), 16'(want.read_byte));
					if (got.rejected != want.rejected)
						flag_mismatch("rejected", 16'(got.rejected), 16'(want.rejected));
				end
			end
			pending = levels_q.size();
		end
	end

endmodule

FILE: tb/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
module i2c_bit_level_master_tb;
	import i2cblm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 1100;
	// kind seven is a no-op request
	localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [15:0] s_axis_tdata  = '0;
	logic [2:0]  s_axis_tuser  = '0;
	logic        m_axis_tready = 1'b1;
	logic        cfg_valid     = 1'b0;
	logic [15:0] cfg_data      = '0;
	logic        s_axis_tready;
	logic        m_axis_tvalid;
	logic [15:0] m_axis_tdata;
	logic        cfg_ready;

	int          errors;
	int          pending;
	int          sent        = 0;
	int          rand_base   = -1;
	int          quiet_cycles = 0;
	bit          steady      = 1'b0;
	logic [15:0] ticks_now   = PHASE_TICKS_RST;

	i2c_bit_level_master dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	i2c_bit_level_master_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99, 0) >= 9);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("i2c_bit_level_master regression: fail");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [KIND_W-1:0] kind, input logic [7:0] wbyte,
			input logic sda);
		while (!steady && $urandom_range(99, 0) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {7'd0, sda, wbyte};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		sent++;
		steady = rand_base >= 0 && sent - rand_base >= 500 && sent - rand_base < 900;
	endtask

	task automatic send_ticks(input int count);
		repeat (count) begin
			send_item(KIND_TICK, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
		end
	endtask

	// sda_mode: 0 drives sda_in low, 1 high, else random
	task automatic run_command(input logic [KIND_W-1:0] kind, input logic [7:0] wbyte,
			input int sda_mode, input int noise_pct, input bit cut);
		int  n;
		int  lim;
		logic sda;
		lim = (ticks_now == '0) ? 1 : ticks_now;
		case (kind)
			KIND_START: n = 5;
			KIND_STOP:  n = 4;
			KIND_WRITE: n = 25;
			KIND_READ:  n = 17;
			KIND_ACK:   n = 4;
			default:    n = 2;
		endcase
		n = n * lim;
		if (cut) n = $urandom_range(n - 1, 0);
		send_item(kind, wbyte, 1'($urandom_range(1, 0)));
		for (int i = 0; i < n; i++) begin
			// rejected commands and no-ops do not count as ticks
			while ($urandom_range(99, 0) < noise_pct) begin
				send_item(3'($urandom_range(7, 1)), 8'($urandom_range(255, 0)),
					1'($urandom_range(1, 0)));
			end
			sda = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 : 1'($urandom_range(1, 0));
			send_item(KIND_TICK, 8'($urandom_range(255, 0)), sda);
		end
	endtask

	task automatic set_ticks(input logic [15:0] v);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		ticks_now = v;
	endtask

	initial begin
		int lim;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset phase length: idle tick, idle no-op, then a start through its
		// first phase end and into the second phase
		send_item(KIND_TICK, 8'h00, 1'b1);
		send_item(KIND_SPARE, 8'hFF, 1'b0);
		send_item(KIND_START, 8'h00, 1'b0);
		send_ticks(330);

		// zero phase length behaves as one; the open start runs out first
		set_ticks(16'h0000);
		send_ticks(6);
		run_command(KIND_WRITE, 8'hFF, 1, 0, 1'b0);
		run_command(KIND_WRITE, 8'h00, 0, 0, 1'b0);
		run_command(KIND_READ, 8'hFF, 1, 0, 1'b0);
		run_command(KIND_READ, 8'h00, 0, 0, 1'b0);
		run_command(KIND_STOP, 8'h5A, 2, 0, 1'b0);
		run_command(KIND_ACK, 8'hA5, 2, 0, 1'b0);
		run_command(KIND_NACK, 8'h3C, 2, 40, 1'b0);

		set_ticks(16'h0001);
		run_command(KIND_READ, 8'h81, 2, 10, 1'b0);

		// longest hold: a phase does not end early; a shorter hold then ends it
		set_ticks(16'hFFFF);
		send_item(KIND_NACK, 8'h00, 1'b0);
		send_ticks(20);
		set_ticks(16'h0001);
		send_ticks(4);

		rand_base = sent;
		while (sent - rand_base < RAND_ITEMS) begin
			case ($urandom_range(9, 0))
				0:       lim = 0;
				1, 2, 3: lim = 1;
				4, 5:    lim = 2;
				6, 7:    lim = 3;
				default: lim = $urandom_range(6, 4);
			endcase
			set_ticks(16'(lim));
			repeat ($urandom_range(8, 3)) begin
				run_command(3'($urandom_range(6, 1)), 8'($urandom_range(255, 0)), 2,
					$urandom_range(8, 0), $urandom_range(9, 0) == 0);
			end
			// flush any broken sequence before the next setting
			if (lim == 0) lim = 1;
			send_ticks(25 * lim);
		end

		s_axis_tvalid <= 1'b0;
		steady = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0 && pending == 0) begin
			$display("i2c_bit_level_master regression: pass");
		end else begin
			$display("i2c_bit_level_master regression: fail");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/i2cblm_pkg.sv
src/i2cblm_phase.sv
src/i2cblm_core.sv
src/i2c_bit_level_master.sv
tb/i2c_bit_level_master_checker.sv
tb/i2c_bit_level_master_tb.sv
